// ===== rtl/pts_pkg.sv =====
// Shared types, constants and the pitch-class function of the pitch track smoother.
package pts_pkg;

	localparam int unsigned RING_DEPTH = 3;
	localparam int unsigned FREQ_W     = 16;
	localparam int unsigned CONF_W     = 9;
	localparam int unsigned CLASS_W    = 4;
	localparam int unsigned ADDR_W     = 4;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CONF_W-1:0] CONF_ONE = 9'd256;

	localparam logic [FREQ_W-1:0] GATE_LOW_RST  = 16'd800;
	localparam logic [FREQ_W-1:0] GATE_HIGH_RST = 16'd32000;
	localparam logic [FREQ_W-1:0] FOLD_LOW_RST  = 16'd3200;
	localparam logic [FREQ_W-1:0] FOLD_HIGH_RST = 16'd15200;

	localparam logic [1:0] REG_GATE_LOW  = 2'd0;
	localparam logic [1:0] REG_GATE_HIGH = 2'd1;
	localparam logic [1:0] REG_FOLD_LOW  = 2'd2;
	localparam logic [1:0] REG_FOLD_HIGH = 2'd3;

	// normalized mantissa at which the rounded note steps up by one
	localparam logic [FREQ_W-1:0] NOTE_EDGES [12] = '{
		16'd34470, 16'd36520, 16'd38691, 16'd40992, 16'd43429, 16'd46012,
		16'd48748, 16'd51646, 16'd54717, 16'd57971, 16'd61418, 16'd65070
	};

	typedef struct packed {
		logic [FREQ_W-1:0] raw_freq;
		logic [CONF_W-1:0] confidence;
	} in_word_t;

	typedef struct packed {
		logic [FREQ_W-1:0]  tracked_freq;
		logic               gate_pass;
		logic               note_valid;
		logic [CLASS_W-1:0] pitch_class;
	} out_word_t;

	typedef struct packed {
		logic [FREQ_W-1:0] gate_low;
		logic [FREQ_W-1:0] gate_high;
		logic [FREQ_W-1:0] fold_low;
		logic [FREQ_W-1:0] fold_high;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [FREQ_W-1:0] value;
		logic              pass;
		logic [CONF_W-1:0] conf;
	} q_word_t;

	function automatic logic [CLASS_W-1:0] note_class(input logic [FREQ_W-1:0] f);
		logic [3:0]        pos;
		logic [FREQ_W-1:0] m;
		logic [3:0]        k;
		pos = 4'd0;
		for (int i = 0; i < FREQ_W; i++) begin
			if (f[i]) begin
				pos = 4'(i);
			end
		end
		m = f << (4'd15 - pos);
		k = 4'd0;
		for (int i = 0; i < 12; i++) begin
			if (m >= NOTE_EDGES[i]) begin
				k = k + 4'd1;
			end
		end
		if (k == 4'd12) begin
			k = 4'd0;
		end
		return k;
	endfunction

endpackage

// ===== rtl/pts_regs.sv =====
// APB register file holding the gate and fold limits.
module pts_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pts_pkg::ADDR_W-1:0] paddr,
	input  logic [pts_pkg::DATA_W-1:0] pwdata,
	output logic [pts_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output pts_pkg::cfg_t              cfg
);
	import pts_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_low  <= GATE_LOW_RST;
			cfg_q.gate_high <= GATE_HIGH_RST;
			cfg_q.fold_low  <= FOLD_LOW_RST;
			cfg_q.fold_high <= FOLD_HIGH_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_GATE_LOW:  cfg_q.gate_low  <= pwdata[FREQ_W-1:0];
				REG_GATE_HIGH: cfg_q.gate_high <= pwdata[FREQ_W-1:0];
				REG_FOLD_LOW:  cfg_q.fold_low  <= pwdata[FREQ_W-1:0];
				REG_FOLD_HIGH: cfg_q.fold_high <= pwdata[FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_GATE_LOW:  prdata[FREQ_W-1:0] = cfg_q.gate_low;
			REG_GATE_HIGH: prdata[FREQ_W-1:0] = cfg_q.gate_high;
			REG_FOLD_LOW:  prdata[FREQ_W-1:0] = cfg_q.fold_low;
			REG_FOLD_HIGH: prdata[FREQ_W-1:0] = cfg_q.fold_high;
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== rtl/pts_front.sv =====
// Front end: median ring, range gate, octave fold and confidence clamp.
module pts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  pts_pkg::in_word_t item,
	input  pts_pkg::cfg_t     cfg,
	output pts_pkg::q_word_t  q_word
);
	import pts_pkg::*;

	logic [FREQ_W-1:0] ring_q [RING_DEPTH];
	logic [1:0]        slot_q;
	logic [1:0]        slot;
	logic [FREQ_W-1:0] a, b, c;
	logic [FREQ_W-1:0] lo, hi, mid, med;
	logic              pass;
	logic [FREQ_W:0]   dbl;
	logic [FREQ_W-1:0] folded;

	// stray slot value wraps to the first entry
	assign slot = (slot_q >= 2'(RING_DEPTH)) ? 2'd0 : slot_q;

	assign a = (slot == 2'd0) ? item.raw_freq : ring_q[0];
	assign b = (slot == 2'd1) ? item.raw_freq : ring_q[1];
	assign c = (slot == 2'd2) ? item.raw_freq : ring_q[2];

	assign lo  = (a < b) ? a : b;
	assign hi  = (a < b) ? b : a;
	assign mid = (hi < c) ? hi : c;
	assign med = (lo > mid) ? lo : mid;

	assign pass = (med > cfg.gate_low) && (med < cfg.gate_high);
	assign dbl  = {med, 1'b0};

	always_comb begin
		if (med < cfg.fold_low) begin
			folded = dbl[FREQ_W] ? '1 : dbl[FREQ_W-1:0];
		end else if (med > cfg.fold_high) begin
			folded = {1'b0, med[FREQ_W-1:1]};
		end else begin
			folded = med;
		end
	end

	assign q_word.value = folded;
	assign q_word.pass  = pass;
	assign q_word.conf  = (item.confidence > CONF_ONE) ? CONF_ONE : item.confidence;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			slot_q <= 2'd0;
		end else if (accept) begin
			ring_q[slot] <= item.raw_freq;
			slot_q       <= (slot == 2'(RING_DEPTH - 1)) ? 2'd0 : slot + 2'd1;
		end
	end

endmodule

// ===== rtl/pts_queue.sv =====
// Two-entry queue between the front end and the tracker.
module pts_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pts_pkg::q_word_t push_word,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output pts_pkg::q_word_t pop_word
);
	import pts_pkg::*;

	q_word_t    mem_q [QUEUE_DEPTH];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign full      = (cnt_q == 2'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != 2'd0);
	assign pop_word  = mem_q[rptr_q];
	assign do_pop    = pop & not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/pts_back.sv =====
// Back end: blends into the tracked value, then names the pitch class.
module pts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  pts_pkg::q_word_t   q_word,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output pts_pkg::out_word_t res
);
	import pts_pkg::*;

	logic [FREQ_W-1:0] trk_q;
	logic              valid_s1;
	logic              pass_s1;
	logic              valid_s2;
	out_word_t         res_s2;
	logic              en_s2;
	logic [CONF_W-1:0] inv_p;
	logic [24:0]       prod_new;
	logic [24:0]       prod_old;
	logic [25:0]       blend;
	logic [FREQ_W-1:0] trk_next;

	assign en_s2 = !valid_s2 || !res_stall;
	assign pop   = q_valid && (!valid_s1 || en_s2);

	assign inv_p    = CONF_ONE - q_word.conf;
	assign prod_new = 25'(q_word.conf * q_word.value);
	assign prod_old = 25'(inv_p * trk_q);
	assign blend    = {1'b0, prod_new} + {1'b0, prod_old};

	always_comb begin
		trk_next = trk_q;
		if (q_word.pass) begin
			trk_next = (trk_q == '0) ? q_word.value : blend[23:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pop) begin
				trk_q <= trk_next;
			end
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (en_s2) begin
				valid_s1 <= 1'b0;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pass_s1 <= q_word.pass;
		end
		if (en_s2 && valid_s1) begin
			res_s2.tracked_freq <= trk_q;
			res_s2.gate_pass    <= pass_s1;
			res_s2.note_valid   <= (trk_q != '0);
			res_s2.pitch_class  <= note_class(trk_q);
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

// ===== rtl/pitch_track_smoother.sv =====
// Top level of the pitch track smoother.
//   channel  | dir | handshake                 | word
//   item     | in  | item_valid / item_stall   | in_word_t  (raw_freq, confidence)
//   res      | out | res_valid / res_stall     | out_word_t (tracked_freq, gate_pass,
//            |     |                           |             note_valid, pitch_class)
//   apb      | in  | psel / penable / pready   | gate and fold limits
// One word per cycle sustained while res_stall is low; res_valid rises once the
// queue pop has moved the word into the blend stage, then into the output stage.
// The tracked value updates at the pop. item_stall rises only when the two-entry
// queue is full; res_stall backs up through the blend stage into the queue.
// Reset clears the median ring, the tracked value and all valid flags.
module pitch_track_smoother (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  pts_pkg::in_word_t          item,
	output logic                       res_valid,
	input  logic                       res_stall,
	output pts_pkg::out_word_t         res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pts_pkg::ADDR_W-1:0] paddr,
	input  logic [pts_pkg::DATA_W-1:0] pwdata,
	output logic [pts_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import pts_pkg::*;

	cfg_t    cfg;
	q_word_t push_word;
	q_word_t pop_word;
	logic    accept;
	logic    full;
	logic    not_empty;
	logic    pop;

	assign item_stall = full;
	assign accept     = item_valid && !full;

	pts_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg),
		.q_word (push_word)
	);

	pts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_word  (pop_word)
	);

	pts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (not_empty),
		.q_word    (pop_word),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== rtl/pts_checker.sv =====
// Port-level checker for the pitch track smoother, bound to the top level.
module pts_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input pts_pkg::out_word_t res
);
	import pts_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("res_valid dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("res word changed while stalled");

	a_note_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.note_valid == (res.tracked_freq != '0)))
		else $error("note_valid disagrees with tracked_freq");

	a_class_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.note_valid |-> (res.pitch_class == '0))
		else $error("pitch_class nonzero without a note");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.pitch_class < 4'd12))
		else $error("pitch_class out of range");

endmodule

bind pitch_track_smoother pts_checker u_pts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// ===== bench/tb_pitch_track_smoother.sv =====
// Testbench for pitch_track_smoother: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module tb_pitch_track_smoother;

	import pts_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 6;

	class track_scoreboard;
		bit [FREQ_W-1:0] gate_low, gate_high, fold_low, fold_high;
		bit [FREQ_W-1:0] ring [RING_DEPTH];
		int unsigned     slot;
		bit [FREQ_W-1:0] track;
		int unsigned     edges [12];
		out_word_t       expected_words [$];
		int unsigned     errors;

		function new();
			gate_low  = 16'd800;
			gate_high = 16'd32000;
			fold_low  = 16'd3200;
			fold_high = 16'd15200;
			foreach (ring[i]) ring[i] = '0;
			slot   = 0;
			track  = '0;
			errors = 0;
			edges  = '{34470, 36520, 38691, 40992, 43429, 46012,
				48748, 51646, 54717, 57971, 61418, 65070};
		endfunction

		function void set_limit(logic [1:0] idx, logic [FREQ_W-1:0] val);
			case (idx)
				REG_GATE_LOW:  gate_low  = val;
				REG_GATE_HIGH: gate_high = val;
				REG_FOLD_LOW:  fold_low  = val;
				REG_FOLD_HIGH: fold_high = val;
				default: ;
			endcase
		endfunction

		function void complain(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 10) begin
				$display("mismatch %s: expected %0d, got %0d", what, want, got);
			end
		endfunction

		// note within the octave from the normalized mantissa
		function bit [CLASS_W-1:0] semitone(bit [FREQ_W-1:0] f);
			bit [FREQ_W-1:0] m;
			int unsigned     k;
			if (f == 0) begin
				return '0;
			end
			m = f;
			while (!m[FREQ_W-1]) m = m << 1;
			k = 0;
			foreach (edges[i]) begin
				if (m >= edges[i]) k++;
			end
			return CLASS_W'(k % 12);
		endfunction

		function void note_item(in_word_t w);
			int unsigned p, lo, hi, mid, med, v;
			bit          gate_ok;
			out_word_t   e;
			p = w.confidence;
			if (p > 256) p = 256;
			ring[slot] = w.raw_freq;
			slot = (slot + 1) % RING_DEPTH;
			lo  = ring[0] < ring[1] ? ring[0] : ring[1];
			hi  = ring[0] < ring[1] ? ring[1] : ring[0];
			mid = hi < ring[2] ? hi : ring[2];
			med = lo > mid ? lo : mid;
			gate_ok = med > gate_low && med < gate_high;
			if (gate_ok) begin
				v = med;
				if (v < fold_low) begin
					v = v << 1;
					if (v > 65535) v = 65535;
				end else if (v > fold_high) begin
					v = v >> 1;
				end
				if (track == 0) track = FREQ_W'(v);
				else track = FREQ_W'((p * v + (256 - p) * track) >> 8);
			end
			e.tracked_freq = track;
			e.gate_pass    = gate_ok;
			e.note_valid   = track != 0;
			e.pitch_class  = semitone(track);
			expected_words.push_back(e);
		endfunction

		function void check_word(out_word_t r);
			out_word_t e;
			if (expected_words.size() == 0) begin
				complain("unexpected word", 0, 32'(r));
				return;
			end
			e = expected_words.pop_front();
			if (r.tracked_freq !== e.tracked_freq)
				complain("tracked_freq", 32'(e.tracked_freq), 32'(r.tracked_freq));
			if (r.gate_pass !== e.gate_pass)
				complain("gate_pass", 32'(e.gate_pass), 32'(r.gate_pass));
			if (r.note_valid !== e.note_valid)
				complain("note_valid", 32'(e.note_valid), 32'(r.note_valid));
			if (r.pitch_class !== e.pitch_class)
				complain("pitch_class", 32'(e.pitch_class), 32'(r.pitch_class));
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	in_word_t          item;
	logic              res_valid;
	logic              res_stall;
	out_word_t         res;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	track_scoreboard sb = new();
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_off_req = 1'b0;
	int  quiet = 0;

	pitch_track_smoother DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) sb.note_item(item);
			if (res_valid && !res_stall) sb.check_word(res);
			if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	// receiver: random stall, plus one long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_off_req) begin
				hold_left = HOLD_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold_left != 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	task automatic send_item(logic [FREQ_W-1:0] raw, logic [CONF_W-1:0] conf);
		in_word_t w;
		w.raw_freq   = raw;
		w.confidence = conf;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall);
	endtask

	// write one limit, then read it back
	task automatic write_reg(logic [1:0] idx, logic [FREQ_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[FREQ_W-1:0] !== val) sb.complain("register readback", 32'(val), prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_limit(idx, val);
	endtask

	task automatic apply_limits(int gl, int gh, int fl, int fh);
		write_reg(REG_GATE_LOW, FREQ_W'(gl));
		write_reg(REG_GATE_HIGH, FREQ_W'(gh));
		write_reg(REG_FOLD_LOW, FREQ_W'(fl));
		write_reg(REG_FOLD_HIGH, FREQ_W'(fh));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly held tones with jitter and octave slips, some pure noise
	task automatic random_words(int n);
		int sent, base, len, jit, r, conf;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 75) begin
				base = $urandom_range(800, 32000);
				len  = $urandom_range(4, 30);
				jit  = base / 64 + 1;
				for (int i = 0; i < len && sent < n; i++) begin
					r = base + $urandom_range(0, 2 * jit) - jit;
					case ($urandom_range(0, 19))
						0: r = base * 2;
						1: r = base / 2;
						2: r = 0;
						default: ;
					endcase
					if (r > 65535) r = 65535;
					if (r < 0) r = 0;
					conf = ($urandom_range(0, 9) < 8) ? $urandom_range(100, 256)
						: $urandom_range(0, 511);
					send_item(FREQ_W'(r), CONF_W'(conf));
					sent++;
				end
			end else begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len && sent < n; i++) begin
					send_item(FREQ_W'($urandom_range(0, 65535)), CONF_W'($urandom_range(0, 511)));
					sent++;
				end
			end
		end
	endtask

	initial begin : stimulus
		int d_raw [24];
		int d_conf [24];
		int gl [6];
		int gh [6];
		int fl [6];
		int fh [6];
		d_raw  = '{0, 801, 801, 801, 65535, 65535, 65535, 32000, 32000, 32000, 31999, 31999,
			31999, 3200, 3200, 3200, 3199, 3199, 15201, 15201, 800, 800, 1, 65535};
		d_conf = '{0, 256, 256, 256, 511, 511, 511, 128, 128, 128, 257, 257,
			257, 1, 1, 1, 0, 0, 200, 200, 64, 64, 511, 256};
		gl = '{800, 0, 0, 0, 0, 65535};
		gh = '{32000, 65535, 65535, 65535, 0, 0};
		fl = '{3200, 0, 65535, 0, 0, 0};
		fh = '{15200, 65535, 65535, 0, 0, 65535};
		gl[4] = $urandom_range(0, 2000);
		gh[4] = $urandom_range(20000, 65535);
		fl[4] = $urandom_range(0, 8000);
		fh[4] = $urandom_range(8000, 40000);

		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (d_raw[i]) send_item(FREQ_W'(d_raw[i]), CONF_W'(d_conf[i]));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph != 0) apply_limits(gl[ph], gh[ph], fl[ph], fh[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 47; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 47; end
				default: begin send_idle_pct = 32; stall_pct = 32; end
			endcase
			if (ph == 0) hold_off_req = 1'b1;
			// halving a median of one leaves the tracker at zero
			if (ph == 3) repeat (3) send_item(FREQ_W'(1), CONF_W'(256));
			random_words(283);
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
